// ===== hdl/page_frame_allocator_macros.svh =====
// Assertion macros used by the page frame allocator checker.
`ifndef PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_MACROS_SVH

// Property checked on every rising edge of clk_i, ignored while reset is low.
`define PFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising edge of clk_i, reset included.
`define PFA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/pfa_pkg.sv =====
// Shared constants and types of the page frame allocator.
`default_nettype none

package pfa_pkg;

  // Page geometry.
  localparam int unsigned MaxPages  = 4096;
  localparam int unsigned PageBytes = 4096;
  localparam int unsigned PnW       = $clog2(MaxPages);
  localparam int unsigned CntW      = PnW + 1;
  localparam int unsigned StW       = 2;

  // Item types carried on action_i.
  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_MARK  = 2'd2
  } action_e;

  // Per-page state codes.
  typedef enum logic [StW-1:0] {
    PS_FREE     = 2'd0,
    PS_USED     = 2'd1,
    PS_UNUSABLE = 2'd2
  } page_state_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OOM    = 2'd1,
    ST_RANGE  = 2'd2,
    ST_DOUBLE = 2'd3
  } status_e;

  // Access to the page state memory.
  typedef struct packed {
    logic           we;
    logic [PnW-1:0] addr;
    logic [StW-1:0] wdata;
  } st_req_t;

  // Access to the next-link memory.
  typedef struct packed {
    logic            we;
    logic [PnW-1:0]  addr;
    logic [CntW-1:0] wdata;
  } link_req_t;

endpackage

`default_nettype wire

// ===== hdl/pfa_ram.sv =====
// Single-port synchronous RAM with a registered read port.
`default_nettype none

module pfa_ram #(
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 2
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int unsigned Depth = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/pfa_ctrl.sv =====
// Sequencer of the page frame allocator: list pop and push, bump scan, marks.
`default_nettype none

module pfa_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    action_i,
  input  logic [pfa_pkg::PnW-1:0]       page_number_i,
  input  logic [1:0]                    mark_state_i,
  input  logic                          cfg_we_i,
  input  logic [pfa_pkg::CntW-1:0]      cfg_data_i,
  output pfa_pkg::st_req_t              st_req_o,
  input  logic [pfa_pkg::StW-1:0]       st_rdata_i,
  output pfa_pkg::link_req_t            link_req_o,
  input  logic [pfa_pkg::CntW-1:0]      link_rdata_i,
  output logic                          done_o,
  output logic [pfa_pkg::PnW-1:0]       page_number_out_o,
  output logic [1:0]                    status_o
);

  import pfa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_POP,
    S_FREE_CHK,
    S_SCAN
  } ctrl_state_e;

  localparam logic [CntW-1:0] NullLink = CntW'(MaxPages);
  localparam logic [PnW-1:0]  LastPage = PnW'(MaxPages - 1);

  ctrl_state_e     state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] head_q, head_d;
  logic [CntW-1:0] cursor_q, cursor_d;
  logic [PnW-1:0]  pn_q, pn_d;
  logic [PnW-1:0]  clr_q, clr_d;
  logic            done_q, done_d;
  logic [PnW-1:0]  pn_out_q, pn_out_d;
  logic [1:0]      status_q, status_d;

  logic [CntW-1:0] limit;
  logic            pn_in_range;
  logic            head_valid;
  logic [1:0]      mark_clamped;
  logic [CntW-1:0] cursor_inc;
  logic [CntW-1:0] link_clamped;

  // Limit in force and per-item decode.
  assign limit        = (count_q > NullLink) ? NullLink : count_q;
  assign pn_in_range  = {1'b0, page_number_i} < limit;
  assign head_valid   = head_q < NullLink;
  assign mark_clamped = (mark_state_i > PS_UNUSABLE) ? PS_UNUSABLE : mark_state_i;
  assign cursor_inc   = cursor_q + CntW'(1);
  assign link_clamped = (link_rdata_i > NullLink) ? NullLink : link_rdata_i;

  // Next-state logic and memory accesses.
  always_comb begin
    state_d    = state_q;
    count_d    = cfg_we_i ? cfg_data_i : count_q;
    head_d     = head_q;
    cursor_d   = cursor_q;
    pn_d       = pn_q;
    clr_d      = clr_q;
    done_d     = 1'b0;
    pn_out_d   = pn_out_q;
    status_d   = status_q;
    st_req_o   = '0;
    link_req_o = '0;

    case (state_q)
      S_CLEAR: begin
        // Sweep every page to unusable after reset.
        st_req_o.we    = 1'b1;
        st_req_o.addr  = clr_q;
        st_req_o.wdata = PS_UNUSABLE;
        clr_d          = clr_q + PnW'(1);
        if (clr_q == LastPage) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          pn_d = page_number_i;
          case (action_i)
            ACT_ALLOC: begin
              if (head_valid) begin
                // Pop: fetch the successor of the head.
                link_req_o.addr = head_q[PnW-1:0];
                pn_d            = head_q[PnW-1:0];
                state_d         = S_POP;
              end else if (cursor_q < limit) begin
                st_req_o.addr = cursor_q[PnW-1:0];
                state_d       = S_SCAN;
              end else begin
                done_d   = 1'b1;
                pn_out_d = '0;
                status_d = ST_OOM;
              end
            end
            ACT_FREE: begin
              if (pn_in_range) begin
                st_req_o.addr = page_number_i;
                state_d       = S_FREE_CHK;
              end else begin
                done_d   = 1'b1;
                pn_out_d = page_number_i;
                status_d = ST_RANGE;
              end
            end
            ACT_MARK: begin
              done_d   = 1'b1;
              pn_out_d = page_number_i;
              if (pn_in_range) begin
                st_req_o.we    = 1'b1;
                st_req_o.addr  = page_number_i;
                st_req_o.wdata = mark_clamped;
                status_d       = ST_OK;
              end else begin
                status_d = ST_RANGE;
              end
            end
            default: begin
              done_d   = 1'b1;
              pn_out_d = page_number_i;
              status_d = ST_OK;
            end
          endcase
        end
      end

      S_POP: begin
        // The popped page leaves the list; hand it out only if in range.
        head_d   = link_clamped;
        done_d   = 1'b1;
        pn_out_d = pn_q;
        state_d  = S_IDLE;
        if ({1'b0, pn_q} < limit) begin
          st_req_o.we    = 1'b1;
          st_req_o.addr  = pn_q;
          st_req_o.wdata = PS_USED;
          status_d       = ST_OK;
        end else begin
          status_d = ST_RANGE;
        end
      end

      S_FREE_CHK: begin
        done_d   = 1'b1;
        pn_out_d = pn_q;
        state_d  = S_IDLE;
        if (st_rdata_i == PS_FREE) begin
          status_d = ST_DOUBLE;
        end else begin
          // Push the page in front of the current head.
          st_req_o.we      = 1'b1;
          st_req_o.addr    = pn_q;
          st_req_o.wdata   = PS_FREE;
          link_req_o.we    = 1'b1;
          link_req_o.addr  = pn_q;
          link_req_o.wdata = head_q;
          head_d           = {1'b0, pn_q};
          status_d         = ST_OK;
        end
      end

      S_SCAN: begin
        // The state of cursor_q is on the read port; the next page is fetched
        // in the same cycle so the scan examines one page per cycle.
        cursor_d = cursor_inc;
        if (st_rdata_i == PS_FREE) begin
          st_req_o.we    = 1'b1;
          st_req_o.addr  = cursor_q[PnW-1:0];
          st_req_o.wdata = PS_USED;
          done_d         = 1'b1;
          pn_out_d       = cursor_q[PnW-1:0];
          status_d       = ST_OK;
          state_d        = S_IDLE;
        end else if (cursor_inc < limit) begin
          st_req_o.addr = cursor_inc[PnW-1:0];
        end else begin
          done_d   = 1'b1;
          pn_out_d = '0;
          status_d = ST_OOM;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      count_q  <= '0;
      head_q   <= NullLink;
      cursor_q <= '0;
      pn_q     <= '0;
      clr_q    <= '0;
      done_q   <= 1'b0;
      pn_out_q <= '0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      head_q   <= head_d;
      cursor_q <= cursor_d;
      pn_q     <= pn_d;
      clr_q    <= clr_d;
      done_q   <= done_d;
      pn_out_q <= pn_out_d;
      status_q <= status_d;
    end
  end

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign page_number_out_o = pn_out_q;
  assign status_o          = status_q;

endmodule

`default_nettype wire

// ===== hdl/page_frame_allocator.sv =====
// Page frame allocator top level: sequencer plus page state and next-link RAMs.
//
//   Channel   Handshake              Payload
//   command   start_i / busy_o       action_i, page_number_i, mark_state_i
//   result    done_o (strobe)        page_number_out_o, status_o
//   config    cfg_valid_i/cfg_ready_o cfg_data_i (page_count)
//
// Mark, a free or mark out of range, out of memory with an exhausted cursor and
// the unused action finish directly from the idle state. Free and a list pop
// first read the state or next-link RAM, then do the write-back.
// A bump scan examines one page per cycle from the cursor,
// bounded by the single read port of the page state RAM.
// After reset the page state RAM is swept to unusable with busy_o high;
// configuration transfers are taken throughout.
// Results are strobed for one cycle and cannot be stalled.
`default_nettype none

module page_frame_allocator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               action_i,
  input  logic [pfa_pkg::PnW-1:0]  page_number_i,
  input  logic [1:0]               mark_state_i,
  output logic                     done_o,
  output logic [pfa_pkg::PnW-1:0]  page_number_out_o,
  output logic [1:0]               status_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [pfa_pkg::CntW-1:0] cfg_data_i
);

  import pfa_pkg::*;

  st_req_t         st_req;
  link_req_t       link_req;
  logic [StW-1:0]  st_rdata;
  logic [CntW-1:0] link_rdata;

  // The register is always ready for a transfer.
  assign cfg_ready_o = 1'b1;

  pfa_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .action_i          (action_i),
    .page_number_i     (page_number_i),
    .mark_state_i      (mark_state_i),
    .cfg_we_i          (cfg_valid_i & cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .st_req_o          (st_req),
    .st_rdata_i        (st_rdata),
    .link_req_o        (link_req),
    .link_rdata_i      (link_rdata),
    .done_o            (done_o),
    .page_number_out_o (page_number_out_o),
    .status_o          (status_o)
  );

  // Page state table.
  pfa_ram #(
    .ADDR_W (PnW),
    .DATA_W (StW)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_req.we),
    .addr_i  (st_req.addr),
    .wdata_i (st_req.wdata),
    .rdata_o (st_rdata)
  );

  // Next-link table of the free list.
  pfa_ram #(
    .ADDR_W (PnW),
    .DATA_W (CntW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_req.we),
    .addr_i  (link_req.addr),
    .wdata_i (link_req.wdata),
    .rdata_o (link_rdata)
  );

endmodule

`default_nettype wire

// ===== hdl/pfa_checker.sv =====
// Port-level checker of the page frame allocator and its bind.
`default_nettype none

`include "page_frame_allocator_macros.svh"

module pfa_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_o,
  input logic                    done_o,
  input logic [pfa_pkg::PnW-1:0] page_number_out_o,
  input logic [1:0]              status_o
);

  import pfa_pkg::*;

  // No result strobe while reset is held.
  `PFA_ASSERT_ALWAYS(a_no_done_in_reset, !rst_ni |-> !done_o, "result strobe during reset")

  // An accepted item either finishes at once or keeps the block busy.
  `PFA_ASSERT(a_accept_progress, (start_i && !busy_o) |=> (done_o || busy_o), "accepted item lost")

  // A result always closes the item: the block is free again.
  `PFA_ASSERT(a_done_not_busy, done_o |-> !busy_o, "result strobe while still busy")

  // A result is only produced by an accepted or ongoing item.
  `PFA_ASSERT(a_done_has_cause, done_o |-> ($past(busy_o) || $past(start_i)), "spurious result")

  // Out of memory always reports page zero.
  `PFA_ASSERT(a_oom_page_zero, (done_o && status_o == ST_OOM) |-> page_number_out_o == '0, "out of memory with nonzero page")

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (.*);

`default_nettype wire

// ===== tb/pfa_ledger_pkg.sv =====
// Scoreboard for the page frame allocator bench: predicted page tables and pending results.
package pfa_ledger_pkg;
  import pfa_pkg::*;

  // One predicted result of the allocator.
  typedef struct packed {
    logic [PnW-1:0] page;
    logic [1:0]     status;
  } grant_t;

  class frame_ledger;
    logic [StW-1:0]  page_state [MaxPages];
    logic [CntW-1:0] next_link [MaxPages];
    logic [CntW-1:0] free_head;
    logic [CntW-1:0] bump_cursor;
    logic [CntW-1:0] page_count;
    grant_t          grants_due[$];
    logic [PnW-1:0]  handed_out[$];
    int unsigned     mismatches;

    // Power-up view: every page unusable, empty list, cursor at page zero.
    function new();
      for (int i = 0; i < MaxPages; i++) begin
        page_state[i] = PS_UNUSABLE;
        next_link[i]  = '0;
      end
      free_head   = MaxPages[CntW-1:0];
      bump_cursor = '0;
      page_count  = '0;
      mismatches  = 0;
    endfunction

    function void set_page_count(logic [CntW-1:0] cnt);
      page_count = cnt;
    endfunction

    function void note_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: %s", what);
      end
    endfunction

    // Apply one accepted command to the tables and queue the result it must produce.
    function void note_command(logic [1:0] act, logic [PnW-1:0] pn, logic [1:0] ms);
      logic [CntW-1:0] lim;
      logic [CntW-1:0] p;
      logic            found;
      grant_t          g;
      lim = (page_count > MaxPages[CntW-1:0]) ? MaxPages[CntW-1:0] : page_count;
      g.page   = pn;
      g.status = ST_OK;
      case (act)
        ACT_ALLOC: begin
          if (free_head < MaxPages[CntW-1:0]) begin
            // Pop the list head; a page past the limit leaves the list but is not handed out.
            p         = free_head;
            free_head = next_link[p[PnW-1:0]];
            g.page    = p[PnW-1:0];
            if (p >= lim) begin
              g.status = ST_RANGE;
            end else begin
              page_state[p[PnW-1:0]] = PS_USED;
              handed_out.push_back(p[PnW-1:0]);
            end
          end else begin
            // The list is empty, so walk forward from the cursor to the first free page.
            found    = 1'b0;
            g.page   = '0;
            g.status = ST_OOM;
            while (!found && bump_cursor < lim) begin
              p           = bump_cursor;
              bump_cursor = bump_cursor + 1'b1;
              if (page_state[p[PnW-1:0]] == PS_FREE) begin
                found                  = 1'b1;
                page_state[p[PnW-1:0]] = PS_USED;
                g.page                 = p[PnW-1:0];
                g.status               = ST_OK;
                handed_out.push_back(p[PnW-1:0]);
              end
            end
          end
        end
        ACT_FREE: begin
          if ({1'b0, pn} >= lim) begin
            g.status = ST_RANGE;
          end else if (page_state[pn] == PS_FREE) begin
            g.status = ST_DOUBLE;
          end else begin
            next_link[pn]  = free_head;
            page_state[pn] = PS_FREE;
            free_head      = {1'b0, pn};
          end
        end
        ACT_MARK: begin
          // The undefined state code counts as unusable.
          if ({1'b0, pn} >= lim) begin
            g.status = ST_RANGE;
          end else begin
            page_state[pn] = (ms > PS_UNUSABLE) ? PS_UNUSABLE : ms;
          end
        end
        default: begin
        end
      endcase
      grants_due.push_back(g);
    endfunction

    // Compare one result transfer with the oldest pending prediction.
    function void check_result(logic [PnW-1:0] pn, logic [1:0] st);
      grant_t want;
      if (grants_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result: page %0d status %0d", pn, st));
      end else begin
        want = grants_due.pop_front();
        if (want.page != pn || want.status != st) begin
          note_mismatch($sformatf("page expected %0d got %0d, status expected %0d got %0d",
                                  want.page, pn, want.status, st));
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/page_frame_allocator_tb.sv =====
// Self-checking bench for the page frame allocator: directed set-up, then random command phases.
module page_frame_allocator_tb;
  import pfa_pkg::*;
  import pfa_ledger_pkg::*;

  localparam logic [1:0] ActUnused     = 2'd3;
  localparam logic [1:0] MarkUndefined = 2'd3;
  localparam int unsigned StallLimit   = 20000;
  localparam int unsigned DrainCycles  = 32;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            start_i       = 1'b0;
  logic [1:0]      action_i      = '0;
  logic [PnW-1:0]  page_number_i = '0;
  logic [1:0]      mark_state_i  = '0;
  logic            cfg_valid_i   = 1'b0;
  logic [CntW-1:0] cfg_data_i    = '0;
  logic            busy_o;
  logic            done_o;
  logic [PnW-1:0]  page_number_out_o;
  logic [1:0]      status_o;
  logic            cfg_ready_o;

  frame_ledger ledger;
  int unsigned idle_pct     = 0;
  int unsigned quiet_cycles = 0;

  page_frame_allocator u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .action_i         (action_i),
    .page_number_i    (page_number_i),
    .mark_state_i     (mark_state_i),
    .done_o           (done_o),
    .page_number_out_o(page_number_out_o),
    .status_o         (status_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  // Clock with a period of 8.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Check every result strobe and stop the run if no transfer happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        ledger.check_result(page_number_out_o, status_o);
      end
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == StallLimit) begin
        $display("page_frame_allocator_tb NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Present one command, with random idle cycles first, and hold it until the transfer.
  task automatic send_item(input logic [1:0] act, input logic [PnW-1:0] pn,
                           input logic [1:0] ms);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    action_i      <= act;
    page_number_i <= pn;
    mark_state_i  <= ms;
    do @(posedge clk_i); while (busy_o);
    ledger.note_command(act, pn, ms);
  endtask

  // Write page_count once every outstanding result has come back.
  task automatic write_page_count(input logic [CntW-1:0] cnt);
    start_i <= 1'b0;
    while (ledger.grants_due.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cnt;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.set_page_count(cnt);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly allocations and frees of pages that were handed out, plus set-up marks and noise.
  task automatic send_random(input int unsigned lim);
    logic [31:0]    rnd;
    int unsigned    roll;
    int unsigned    span;
    int unsigned    idx;
    logic [PnW-1:0] pn;
    logic [1:0]     ms;
    rnd  = $urandom;
    roll = $urandom_range(99);
    span = (lim == 0) ? 1 : lim;
    idx  = $urandom_range(span - 1);
    pn   = idx[PnW-1:0];
    ms   = ($urandom_range(1) == 0) ? PS_FREE : rnd[1:0];
    if (roll < 38) begin
      send_item(ACT_ALLOC, rnd[13:2], rnd[15:14]);
    end else if (roll < 68) begin
      if (ledger.handed_out.size() != 0 && $urandom_range(9) < 7) begin
        idx = $urandom_range(ledger.handed_out.size() - 1);
        pn  = ledger.handed_out[idx];
        ledger.handed_out.delete(idx);
      end else if ($urandom_range(3) == 0) begin
        idx = $urandom_range(span + 8);
        pn  = idx[PnW-1:0];
      end
      send_item(ACT_FREE, pn, rnd[15:14]);
    end else if (roll < 93) begin
      send_item(ACT_MARK, pn, ms);
    end else begin
      send_item(rnd[17:16], rnd[29:18], rnd[31:30]);
    end
  endtask

  task automatic run_phase(input logic [CntW-1:0] cnt, input int unsigned idle,
                           input int unsigned n);
    int unsigned lim;
    write_page_count(cnt);
    idle_pct = idle;
    lim      = (cnt > MaxPages) ? MaxPages : cnt;
    repeat (n) send_random(lim);
  endtask

  initial begin
    ledger = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Nothing is managed yet: out of memory, out-of-range free, unused action.
    send_item(ACT_ALLOC, 12'd0, PS_FREE);
    send_item(ACT_FREE, 12'd4095, PS_USED);
    send_item(ActUnused, 12'hABC, MarkUndefined);

    // Set up a small map and take pages from the cursor.
    write_page_count(13'd16);
    send_item(ACT_MARK, 12'd0, PS_FREE);
    send_item(ACT_MARK, 12'd1, PS_USED);
    send_item(ACT_MARK, 12'd2, PS_UNUSABLE);
    send_item(ACT_MARK, 12'd3, MarkUndefined);
    send_item(ACT_MARK, 12'd16, PS_FREE);
    send_item(ACT_MARK, 12'd4, PS_FREE);
    send_item(ACT_ALLOC, 12'd0, PS_FREE);
    send_item(ACT_ALLOC, 12'd0, PS_FREE);
    send_item(ACT_ALLOC, 12'd0, PS_FREE);

    // List pushes, a double free, a free of an unusable page, then pops until empty.
    send_item(ACT_FREE, 12'd4, PS_FREE);
    send_item(ACT_FREE, 12'd4, PS_FREE);
    send_item(ACT_FREE, 12'd2, PS_FREE);
    send_item(ACT_FREE, 12'd1, PS_FREE);
    send_item(ACT_ALLOC, 12'd0, PS_FREE);
    send_item(ACT_ALLOC, 12'd0, PS_FREE);
    send_item(ACT_ALLOC, 12'd0, PS_FREE);
    send_item(ACT_ALLOC, 12'd0, PS_FREE);

    // A listed page marked used is still handed out.
    send_item(ACT_FREE, 12'd15, PS_FREE);
    send_item(ACT_MARK, 12'd15, PS_USED);
    send_item(ACT_ALLOC, 12'd0, PS_FREE);

    // Shrinking the limit leaves a stale list entry and the cursor past the limit.
    send_item(ACT_FREE, 12'd12, PS_FREE);
    write_page_count(13'd10);
    send_item(ACT_ALLOC, 12'd0, PS_FREE);
    send_item(ACT_ALLOC, 12'd0, PS_FREE);

    // Random phases over several limits, from none to beyond the table size.
    run_phase(13'd24, 0, 150);
    run_phase(13'd64, 87, 150);
    run_phase(13'd1, 8, 80);
    run_phase(13'd200, 0, 180);
    run_phase(13'd0, 87, 50);
    run_phase(13'd128, 8, 180);
    run_phase(13'd4096, 87, 180);
    run_phase(13'd8191, 0, 180);
    run_phase(13'd40, 8, 80);
    start_i <= 1'b0;

    // Wait for the last results, then drain for DrainCycles to catch anything spurious.
    while (ledger.grants_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (ledger.grants_due.size() != 0) begin
      ledger.note_mismatch($sformatf("%0d results never arrived", ledger.grants_due.size()));
    end
    if (ledger.mismatches == 0) begin
      $display("page_frame_allocator_tb OK");
    end else begin
      $display("page_frame_allocator_tb NOT OK");
    end
    $finish;
  end

endmodule
